// File: src/bcpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier evaluator package
// Shared constants, the control point type and the sequencer state type.
// ----------------------------------------------------------------------------
package bcpe_pkg;

   localparam int MAX_POINTS = 8;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int LVL_W      = $clog2(MAX_POINTS);

   localparam int COORD_W    = 24;
   localparam int T_W        = 17;
   localparam int DEG_W      = 3;
   localparam int PIDX_W     = 3;

   localparam logic [T_W-1:0]   T_ONE      = 17'h10000;
   localparam logic [DEG_W-1:0] DEG_RESET  = 3'd5;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 72;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   typedef struct packed {
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } point_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_DROP,
      ST_FLUSH
   } state_type;

endpackage

// File: src/bcpe_lerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier evaluator interpolation unit
// One de Casteljau step on three coordinate lanes: p + floor((q - p) * t / 2^16).
// ----------------------------------------------------------------------------
module bcpe_lerp (
   input  bcpe_pkg::point_type            p_pt,
   input  bcpe_pkg::point_type            q_pt,
   input  logic [bcpe_pkg::T_W-1:0]       t_val,
   output bcpe_pkg::point_type            r_pt
);

   localparam int DIFF_W = bcpe_pkg::COORD_W + 1;
   localparam int PROD_W = DIFF_W + bcpe_pkg::T_W + 1;
   localparam int SUM_W  = PROD_W - 16;

   function automatic logic signed [bcpe_pkg::COORD_W-1:0] lerp_coord(
      input logic signed [bcpe_pkg::COORD_W-1:0] p,
      input logic signed [bcpe_pkg::COORD_W-1:0] q,
      input logic        [bcpe_pkg::T_W-1:0]     t
   );
      logic signed [DIFF_W-1:0] diff;
      logic signed [PROD_W-1:0] prod;
      logic signed [SUM_W-1:0]  sum;
      diff = DIFF_W'(q) - DIFF_W'(p);
      prod = PROD_W'(diff) * PROD_W'(signed'({1'b0, t}));
      // arithmetic shift by 16 is the floor of the quotient
      sum  = prod[PROD_W-1:16] + SUM_W'(p);
      return sum[bcpe_pkg::COORD_W-1:0];
   endfunction

   always_comb begin
      r_pt.x = lerp_coord(p_pt.x, q_pt.x, t_val);
      r_pt.y = lerp_coord(p_pt.y, q_pt.y, t_val);
      r_pt.z = lerp_coord(p_pt.z, q_pt.z, t_val);
   end

endmodule

// File: src/bezier_curve_point_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier curve point evaluator
// Loads 3D control points into a small store and evaluates the curve at t by
// de Casteljau interpolation on one shared three-lane interpolation unit.
// ----------------------------------------------------------------------------
// Sequence: a load item writes the store; the sequencer stays idle. An evaluate item
//   copies the store to the work line, then per level does one step per cycle on the
//   single unit (ST_STEP), one drop shift (ST_DROP), then fills the output (ST_FLUSH).
// Throughput: one item at a time; req_tready is low while an evaluation runs.
// Reset: synchronous, active high; clears the sequencer and the output valid,
//   holds req_tready low and sets curve_degree to 5. The store is not cleared.
module bezier_curve_point_evaluator (
   input  logic                                 clock,
   input  logic                                 reset,
   // item in
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // point_index[2:0], coord_x[26:3], coord_y[50:27], coord_z[74:51],
   // param_t[91:75], zero fill[95:92]
   input  logic [bcpe_pkg::REQ_DATA_W-1:0]      req_tdata,
   // cmd[0]
   input  logic [0:0]                           req_tuser,
   // result out
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // curve_x[23:0], curve_y[47:24], curve_z[71:48]
   output logic [bcpe_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // curve_degree register
   input  logic                                 csr_we,
   input  logic [bcpe_pkg::DEG_W-1:0]           csr_wdata
);

   localparam int NP = bcpe_pkg::MAX_POINTS;

   // Unpack the request item.
   logic                               req_cmd;
   logic [bcpe_pkg::PIDX_W-1:0]        req_point_index;
   bcpe_pkg::point_type                req_point;
   logic [bcpe_pkg::T_W-1:0]           req_param_t;
   logic [bcpe_pkg::T_W-1:0]           t_sat;

   assign req_cmd         = req_tuser[0];
   assign req_point_index = req_tdata[2:0];
   assign req_point.x     = req_tdata[26:3];
   assign req_point.y     = req_tdata[50:27];
   assign req_point.z     = req_tdata[74:51];
   assign req_param_t     = req_tdata[91:75];
   // Clamp t to 1.0.
   assign t_sat = (req_param_t > bcpe_pkg::T_ONE) ? bcpe_pkg::T_ONE : req_param_t;

   // Registers.
   bcpe_pkg::state_type                state_ff, state_in;
   logic [bcpe_pkg::LVL_W-1:0]         level_ff, level_in;
   logic [bcpe_pkg::LVL_W-1:0]         step_ff, step_in;
   logic [bcpe_pkg::T_W-1:0]           t_ff;
   logic [bcpe_pkg::DEG_W-1:0]         deg_ff;
   bcpe_pkg::point_type                work_ff [NP];
   bcpe_pkg::point_type                work_in [NP];
   logic                               rsp_valid_ff, rsp_valid_in;
   bcpe_pkg::point_type                rsp_data_ff;

   // Control point store: one write port, copied whole into the work line.
   bcpe_pkg::point_type                cp_store [NP];

   // Sequencer controls.
   logic                               accept;
   logic                               eval_go;
   logic                               load_go;
   logic                               out_free;
   logic                               rsp_load;
   logic                               shift_en;
   logic                               insert_en;
   logic [bcpe_pkg::LVL_W-1:0]         deg_eff;
   bcpe_pkg::point_type                lerp_out;

   // Degree is capped at one less than the store size.
   assign deg_eff = (int'(deg_ff) > NP - 1) ? bcpe_pkg::LVL_W'(NP - 1)
                                            : bcpe_pkg::LVL_W'(deg_ff);

   // Shared interpolation unit: always works on the two head entries.
   bcpe_lerp u_lerp (
      .p_pt  (work_ff[0]),
      .q_pt  (work_ff[1]),
      .t_val (t_ff),
      .r_pt  (lerp_out)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bcpe_pkg::ST_IDLE: begin
            if (eval_go) begin
               state_in = (deg_eff == '0) ? bcpe_pkg::ST_FLUSH : bcpe_pkg::ST_STEP;
            end
         end
         bcpe_pkg::ST_STEP: begin
            // last interpolation of this level
            if (step_ff == level_ff - 1'b1) begin
               state_in = bcpe_pkg::ST_DROP;
            end
         end
         bcpe_pkg::ST_DROP: begin
            state_in = (level_ff == bcpe_pkg::LVL_W'(1)) ? bcpe_pkg::ST_FLUSH
                                                         : bcpe_pkg::ST_STEP;
         end
         bcpe_pkg::ST_FLUSH: begin
            if (out_free) begin
               state_in = bcpe_pkg::ST_IDLE;
            end
         end
         default: state_in = bcpe_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready = (state_ff == bcpe_pkg::ST_IDLE) && !reset;
      accept     = req_tvalid && req_tready;
      eval_go    = accept && (req_cmd == bcpe_pkg::CMD_EVAL);
      load_go    = accept && (req_cmd == bcpe_pkg::CMD_LOAD)
                   && (int'(req_point_index) < NP);
      out_free   = !rsp_valid_ff || rsp_tready;
      rsp_load   = (state_ff == bcpe_pkg::ST_FLUSH) && out_free;
      shift_en   = (state_ff == bcpe_pkg::ST_STEP) || (state_ff == bcpe_pkg::ST_DROP);
      insert_en  = (state_ff == bcpe_pkg::ST_STEP);
   end

   // Counters: level counts down from the degree, step runs across a level.
   always_comb begin
      level_in = level_ff;
      step_in  = '0;
      if (eval_go) begin
         level_in = deg_eff;
      end else if (state_ff == bcpe_pkg::ST_DROP) begin
         level_in = level_ff - 1'b1;
      end
      if (state_ff == bcpe_pkg::ST_STEP) begin
         step_in = step_ff + 1'b1;
      end
   end

   // Work line. Each step shifts down by one and drops the new point in at
   // the current level, so after a level plus one drop shift the next level
   // sits at the head in order.
   always_comb begin
      for (int k = 0; k < NP; k++) begin
         work_in[k] = work_ff[k];
      end
      if (eval_go) begin
         for (int k = 0; k < NP; k++) begin
            work_in[k] = cp_store[k];
         end
      end else if (shift_en) begin
         for (int k = 0; k < NP - 1; k++) begin
            work_in[k] = (insert_en && level_ff == bcpe_pkg::LVL_W'(k)) ? lerp_out
                                                                        : work_ff[k + 1];
         end
         if (insert_en && level_ff == bcpe_pkg::LVL_W'(NP - 1)) begin
            work_in[NP - 1] = lerp_out;
         end
      end
   end

   // Output register: hold until taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bcpe_pkg::ST_IDLE;
         level_ff     <= '0;
         step_ff      <= '0;
         deg_ff       <= bcpe_pkg::DEG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            deg_ff <= csr_wdata;
         end
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      if (eval_go) begin
         t_ff <= t_sat;
      end
      if (rsp_load) begin
         rsp_data_ff <= work_ff[0];
      end
      for (int k = 0; k < NP; k++) begin
         work_ff[k] <= work_in[k];
      end
   end

   // Store write.
   always_ff @(posedge clock) begin
      if (load_go) begin
         cp_store[bcpe_pkg::IDX_W'(req_point_index)] <= req_point;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: src/bcpe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier evaluator port checker
// Watches the top level's ports for sequencing and handshake slips.
// ----------------------------------------------------------------------------
module bcpe_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [0:0]                         req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [bcpe_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   // A stalled result holds.
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("stalled result changed");

   // An evaluate item busies the block.
   property p_eval_busy;
      @(posedge clock) disable iff (reset)
         req_tvalid && req_tready && (req_tuser[0] == bcpe_pkg::CMD_EVAL) |=> !req_tready;
   endproperty
   a_eval_busy: assert property (p_eval_busy) else $error("ready after evaluate item");

   // A load item leaves the input ready in the following cycle.
   property p_load_quick;
      @(posedge clock) disable iff (reset)
         req_tvalid && req_tready && (req_tuser[0] == bcpe_pkg::CMD_LOAD) |=> req_tready;
   endproperty
   a_load_quick: assert property (p_load_quick) else $error("load item stalled input");

   // Reset drops any pending result.
   property p_reset_clear;
      @(posedge clock) reset |=> !rsp_tvalid;
   endproperty
   a_reset_clear: assert property (p_reset_clear) else $error("result valid after reset");

endmodule

bind bezier_curve_point_evaluator bcpe_checker u_bcpe_checker (.*);

// File: tb/bezier_curve_point_evaluator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier curve point evaluator testbench
// Loads control points and evaluates curves at many t values, over several
// curve degrees, with random gaps on the request side and random stalls on
// the result side. A small scoreboard keeps its own copy of the point store
// and the degree. It predicts each curve point by de Casteljau interpolation
// and checks every result against it in order.
// ----------------------------------------------------------------------------
module bezier_curve_point_evaluator_tb;

   localparam int CLK_PERIOD    = 8;
   localparam int SETTLE_CYCLES = 48;      // covers the longest evaluation
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_ITEMS   = 60;

   // -------------------------------------------------------------------------
   // Scoreboard: mirror of the point store plus the queue of predicted points
   // -------------------------------------------------------------------------
   class bezier_scoreboard;
      bcpe_pkg::point_type           ctrl_pts[bcpe_pkg::MAX_POINTS];
      logic [bcpe_pkg::DEG_W-1:0]    degree;
      bcpe_pkg::point_type           pending_points[$];
      int                            fails;

      function new();
         degree = bcpe_pkg::DEG_RESET;
         fails  = 0;
         foreach (ctrl_pts[i]) ctrl_pts[i] = '0;
      endfunction

      function void set_degree(logic [bcpe_pkg::DEG_W-1:0] d);
         degree = d;
      endfunction

      function int pending();
         return pending_points.size();
      endfunction

      // p + floor((q - p) * t / 2^16); the arithmetic shift does the floor
      function int lerp(int p, int q, longint t);
         longint diff;
         diff = longint'(q) - longint'(p);
         return p + int'((diff * t) >>> 16);
      endfunction

      function bcpe_pkg::point_type interpolate_curve(logic [bcpe_pkg::T_W-1:0] t_in);
         int                  w[bcpe_pkg::MAX_POINTS][3];
         int                  d;
         longint              t;
         bcpe_pkg::point_type res;
         t = (t_in > bcpe_pkg::T_ONE) ? longint'(bcpe_pkg::T_ONE) : longint'(t_in);
         d = (int'(degree) > bcpe_pkg::MAX_POINTS - 1) ? bcpe_pkg::MAX_POINTS - 1
                                                       : int'(degree);
         for (int i = 0; i < bcpe_pkg::MAX_POINTS; i++) begin
            w[i][0] = int'($signed(ctrl_pts[i].x));
            w[i][1] = int'($signed(ctrl_pts[i].y));
            w[i][2] = int'($signed(ctrl_pts[i].z));
         end
         for (int lvl = d; lvl > 0; lvl--)
            for (int i = 0; i < lvl; i++)
               for (int c = 0; c < 3; c++)
                  w[i][c] = lerp(w[i][c], w[i + 1][c], t);
         res.x = 24'(w[0][0]);
         res.y = 24'(w[0][1]);
         res.z = 24'(w[0][2]);
         return res;
      endfunction

      function void note_request(logic cmd, logic [bcpe_pkg::PIDX_W-1:0] idx,
                                 bcpe_pkg::point_type pt, logic [bcpe_pkg::T_W-1:0] t);
         if (cmd == bcpe_pkg::CMD_LOAD) begin
            if (int'(idx) < bcpe_pkg::MAX_POINTS) ctrl_pts[idx] = pt;
         end else begin
            pending_points.push_back(interpolate_curve(t));
         end
      endfunction

      function void compare_field(string name, logic [bcpe_pkg::COORD_W-1:0] exp_v,
                                  logic [bcpe_pkg::COORD_W-1:0] act_v);
         if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
            fails++;
         end
      endfunction

      function void check_result(logic [bcpe_pkg::RSP_DATA_W-1:0] data);
         bcpe_pkg::point_type exp_pt;
         if (pending_points.size() == 0) begin
            $error("curve point: expected none, got %h", data);
            fails++;
            return;
         end
         exp_pt = pending_points.pop_front();
         compare_field("curve_x", exp_pt.x, data[23:0]);
         compare_field("curve_y", exp_pt.y, data[47:24]);
         compare_field("curve_z", exp_pt.z, data[71:48]);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block ports, all driven to known values from time zero
   // -------------------------------------------------------------------------
   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [bcpe_pkg::REQ_DATA_W-1:0]   req_tdata  = '0;
   logic [0:0]                        req_tuser  = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b1;
   logic [bcpe_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                              csr_we     = 1'b0;
   logic [bcpe_pkg::DEG_W-1:0]        csr_wdata  = '0;

   bezier_scoreboard                  scoreboard  = new();
   bit                                idle_on     = 1'b1;
   int                                cycle_count = 0;
   int                                stall_left  = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   bezier_curve_point_evaluator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result side: check the item taken at this edge (pre-edge values), then
   // pick the ready level for the next cycle, stalling in short bursts.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) scoreboard.check_result(rsp_tdata);
      if (stall_left > 0)
         stall_left--;
      else if (idle_on && $urandom_range(0, 5) == 0)
         stall_left = $urandom_range(1, 5);
      rsp_tready <= (stall_left == 0);
   end

   // Coordinate with a bias toward the extremes and the all-ones pattern
   function automatic logic [bcpe_pkg::COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 7))
         0:       return 24'h7FFFFF;
         1:       return 24'h800000;
         2:       return 24'h000000;
         3:       return 24'hFFFFFF;
         default: return 24'($urandom);
      endcase
   endfunction

   // Parameter: the ends, their neighbors, saturating values and plain random
   function automatic logic [bcpe_pkg::T_W-1:0] rand_param();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return bcpe_pkg::T_ONE;
         2:       return 17'(bcpe_pkg::T_ONE - 1);
         3:       return 17'd1;
         4:       return 17'($urandom_range(65537, 131071));
         5:       return 17'($urandom);
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   // Present one item, with an optional idle burst in front; return at the
   // edge where it is taken and hand it to the scoreboard.
   task automatic send_item(logic cmd, logic [bcpe_pkg::PIDX_W-1:0] idx,
                            bcpe_pkg::point_type pt, logic [bcpe_pkg::T_W-1:0] t);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0, t, pt, idx};
      do @(posedge clock); while (!req_tready);
      scoreboard.note_request(cmd, idx, pt, t);
   endtask

   // Load a point; param_t is ignored, so fill it with noise
   task automatic load_point(int idx, logic [bcpe_pkg::COORD_W-1:0] x,
                             logic [bcpe_pkg::COORD_W-1:0] y,
                             logic [bcpe_pkg::COORD_W-1:0] z);
      bcpe_pkg::point_type pt;
      pt.x = x;
      pt.y = y;
      pt.z = z;
      send_item(bcpe_pkg::CMD_LOAD, bcpe_pkg::PIDX_W'(idx), pt, 17'($urandom));
   endtask

   // Evaluate at t; the index and coordinates are ignored, so fill with noise
   task automatic eval_curve(logic [bcpe_pkg::T_W-1:0] t);
      bcpe_pkg::point_type pt;
      pt.x = rand_coord();
      pt.y = rand_coord();
      pt.z = rand_coord();
      send_item(bcpe_pkg::CMD_EVAL, bcpe_pkg::PIDX_W'($urandom), pt, t);
   endtask

   // Drop valid, wait for every predicted point, then let a trailing load
   // or evaluation finish before touching the register.
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_degree(int d);
      settle_idle();
      csr_we    <= 1'b1;
      csr_wdata <= bcpe_pkg::DEG_W'(d);
      @(posedge clock);
      csr_we    <= 1'b0;
      scoreboard.set_degree(bcpe_pkg::DEG_W'(d));
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int                  phase_degrees[10];
      bcpe_pkg::point_type pt;

      phase_degrees = '{7, 0, 1, 2, 3, 4, 5, 6, 7, 3};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Fill every slot first; the store is not cleared by reset, so no
      // evaluation may run before points 0..7 hold known values.
      load_point(0, 24'h7FFFFF, 24'h800000, 24'h000000);
      load_point(1, 24'h800000, 24'h7FFFFF, 24'hFFFFFF);
      load_point(2, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      load_point(3, 24'h800000, 24'h800000, 24'h800000);
      load_point(4, 24'h000000, 24'hFFFFFF, 24'h000001);
      load_point(5, 24'h555555, 24'hAAAAAA, 24'h555555);
      load_point(6, 24'hAAAAAA, 24'h555555, 24'hAAAAAA);
      load_point(7, 24'h123456, 24'hEDCBA9, 24'h7FFFFF);

      // Reset degree (5): both ends, the middle, near-ends and saturation
      eval_curve(17'd0);
      eval_curve(bcpe_pkg::T_ONE);
      eval_curve(17'd32768);
      eval_curve(17'd1);
      eval_curve(17'(bcpe_pkg::T_ONE - 1));
      eval_curve(17'(bcpe_pkg::T_ONE + 1));
      eval_curve(17'h1FFFF);

      // Highest degree, every point in play
      write_degree(7);
      eval_curve(17'd0);
      eval_curve(bcpe_pkg::T_ONE);
      eval_curve(17'h1FFFF);
      eval_curve(17'd12345);

      // Degree zero returns point 0 whatever t is
      write_degree(0);
      eval_curve(17'd40000);
      eval_curve(bcpe_pkg::T_ONE);
      load_point(0, 24'h000001, 24'h800000, 24'h7FFFFF);
      eval_curve(17'd0);

      // Random phases, one per degree setting; the last one runs without
      // idling on either side
      for (int ph = 0; ph < 10; ph++) begin
         write_degree(phase_degrees[ph]);
         if (ph == 9) idle_on = 1'b0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 9) < 4) begin
               pt.x = rand_coord();
               pt.y = rand_coord();
               pt.z = rand_coord();
               load_point($urandom_range(0, bcpe_pkg::MAX_POINTS - 1), pt.x, pt.y, pt.z);
            end else begin
               eval_curve(rand_param());
            end
         end
      end

      settle_idle();
      if (scoreboard.fails == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: files.f
src/bcpe_pkg.sv
src/bcpe_lerp.sv
src/bezier_curve_point_evaluator.sv
src/bcpe_checker.sv
tb/bezier_curve_point_evaluator_tb.sv
